FILE: rtl/core/html_entity_stream_decoder_assert.svh
// Assertion macros for the entity decoder, clocked on clock and disabled in reset.
`ifndef HTML_ENTITY_STREAM_DECODER_ASSERT_SVH
`define HTML_ENTITY_STREAM_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HESD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HESD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hesd_pkg.sv
`timescale 1ns / 1ps

package hesd_pkg;

   localparam int BUFFER_BYTES = 16;
   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
   localparam int NAMES = 6;

   localparam logic [7:0] AMP_CHAR = 8'h26;
   localparam logic [7:0] SEMI_CHAR = 8'h3B;
   localparam logic [7:0] SPECIAL_MAX = 8'h20;

   typedef struct packed {
      logic       mode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Names in order: lt, gt, amp, mdash, minus, pi.
   function automatic logic [2:0] name_len(input logic [2:0] k);
      logic [2:0] len;
      case (k)
         3'd0: len = 3'd2;
         3'd1: len = 3'd2;
         3'd2: len = 3'd3;
         3'd3: len = 3'd5;
         3'd4: len = 3'd5;
         3'd5: len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] pos);
      logic [39:0] chars;
      case (k)
         3'd0: chars = {"l", "t", 24'h0};
         3'd1: chars = {"g", "t", 24'h0};
         3'd2: chars = {"a", "m", "p", 16'h0};
         3'd3: chars = {"m", "d", "a", "s", "h"};
         3'd4: chars = {"m", "i", "n", "u", "s"};
         3'd5: chars = {"p", "i", 24'h0};
         default: chars = '0;
      endcase
      case (pos)
         3'd0: return chars[39:32];
         3'd1: return chars[31:24];
         3'd2: return chars[23:16];
         3'd3: return chars[15:8];
         3'd4: return chars[7:0];
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [1:0] repl_len(input logic [2:0] k);
      logic [1:0] len;
      case (k)
         3'd3: len = 2'd3;
         3'd4: len = 2'd3;
         3'd5: len = 2'd2;
         default: len = 2'd1;
      endcase
      return len;
   endfunction

   function automatic logic [23:0] repl_bytes(input logic [2:0] k);
      logic [23:0] b;
      case (k)
         3'd0: b = {8'h3C, 16'h0};
         3'd1: b = {8'h3E, 16'h0};
         3'd2: b = {8'h26, 16'h0};
         3'd3: b = {8'hE2, 8'h80, 8'h94};
         3'd4: b = {8'hE2, 8'h88, 8'h92};
         3'd5: b = {8'hCF, 8'h80, 8'h00};
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/core/html_entity_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming decoder for named character references (lt, gt, amp, mdash, minus, pi).
// Each request transfer is a text byte or an end-of-stream marker; each response transfer
// is one output byte, with last set on the final byte caused by that request. After a
// request is taken, req_ready stays low while its bytes are sequenced: a byte that is
// buffered leaves the decoder idle, a byte that passes through is sent from ST_TAIL, and
// a flush reads the name buffer one entry at a time with a registered read (ST_MEM_RD,
// then ST_MEM_WR) before any trailing bytes. Stalls on rsp_ready hold the sequencing, and
// a new byte is not taken until the bytes of the last one have been sequenced.
module html_entity_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hesd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hesd_pkg::rsp_type rsp_data
);

`include "html_entity_stream_decoder_assert.svh"

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MEM_RD = 2'd1;
   localparam logic [1:0] ST_MEM_WR = 2'd2;
   localparam logic [1:0] ST_TAIL   = 2'd3;

   localparam int FW = hesd_pkg::FILL_W;
   localparam int AW = hesd_pkg::ADDR_W;

   logic [1:0]                 state_ff, state_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic [hesd_pkg::NAMES-1:0] mask_ff, mask_in;
   logic [FW-1:0]              flush_len_ff, flush_len_in;
   logic [FW-1:0]              ptr_ff, ptr_in;
   logic [2:0][7:0]            tail_ff, tail_in;
   logic [1:0]                 tail_len_ff, tail_len_in;
   logic [1:0]                 tail_idx_ff, tail_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   hesd_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic [7:0]                 rd_data_ff;

   logic [7:0]    name_mem [hesd_pkg::BUFFER_BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   logic          slot_free;
   logic          hit;
   logic [2:0]    hit_k;
   logic [FW-1:0] pos_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pos_w     = fill_ff - FW'(1);

   always_comb begin
      hit   = 1'b0;
      hit_k = 3'd0;
      for (int k = 0; k < hesd_pkg::NAMES; k++) begin
         if (!hit && mask_ff[k]
             && fill_ff == FW'(hesd_pkg::name_len(3'(k))) + FW'(1)) begin
            hit   = 1'b1;
            hit_k = 3'(k);
         end
      end
   end

   always_comb begin
      logic [7:0]    ch;
      logic [FW-1:0] fl;
      logic [1:0]    tl;
      logic [23:0]   tb;
      ch           = req_data.in_byte;
      fl           = '0;
      tl           = 2'd0;
      tb           = '0;
      state_in     = state_ff;
      fill_in      = fill_ff;
      mask_in      = mask_ff;
      flush_len_in = flush_len_ff;
      ptr_in       = ptr_ff;
      tail_in      = tail_ff;
      tail_len_in  = tail_len_ff;
      tail_idx_in  = tail_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode) begin
                  fl      = fill_ff;
                  fill_in = '0;
               end else if (fill_ff != '0) begin
                  if (ch <= hesd_pkg::SPECIAL_MAX) begin
                     fl      = fill_ff;
                     tl      = 2'd1;
                     tb      = {ch, 16'h0};
                     fill_in = '0;
                  end else if (ch == hesd_pkg::AMP_CHAR) begin
                     // Entry zero always holds an ampersand, so rewriting it here
                     // leaves the flush of the old buffer unchanged.
                     fl        = fill_ff;
                     fill_in   = FW'(1);
                     mask_in   = '1;
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = hesd_pkg::AMP_CHAR;
                  end else if (ch == hesd_pkg::SEMI_CHAR) begin
                     if (hit) begin
                        tl = hesd_pkg::repl_len(hit_k);
                        tb = hesd_pkg::repl_bytes(hit_k);
                     end else begin
                        fl = fill_ff;
                        tl = 2'd1;
                        tb = {hesd_pkg::SEMI_CHAR, 16'h0};
                     end
                     fill_in = '0;
                  end else if (fill_ff >= FW'(hesd_pkg::BUFFER_BYTES)) begin
                     fl      = fill_ff;
                     tl      = 2'd1;
                     tb      = {ch, 16'h0};
                     fill_in = '0;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = fill_ff[AW-1:0];
                     mem_wdata = ch;
                     fill_in   = fill_ff + FW'(1);
                     for (int k = 0; k < hesd_pkg::NAMES; k++) begin
                        mask_in[k] = mask_ff[k]
                           && pos_w < FW'(hesd_pkg::name_len(3'(k)))
                           && ch == hesd_pkg::name_char(3'(k), pos_w[2:0]);
                     end
                  end
               end else if (ch == hesd_pkg::AMP_CHAR) begin
                  fill_in   = FW'(1);
                  mask_in   = '1;
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = hesd_pkg::AMP_CHAR;
               end else begin
                  tl = 2'd1;
                  tb = {ch, 16'h0};
               end
               flush_len_in = fl;
               tail_len_in  = tl;
               tail_in      = {tb[7:0], tb[15:8], tb[23:16]};
               ptr_in       = '0;
               tail_idx_in  = 2'd0;
               if (fl != '0) begin
                  state_in = ST_MEM_RD;
               end else if (tl != 2'd0) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MEM_RD: begin
            state_in = ST_MEM_WR;
         end
         ST_MEM_WR: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_byte = rd_data_ff;
               rsp_data_in.last     = (ptr_ff == flush_len_ff - FW'(1))
                                      && (tail_len_ff == 2'd0);
               ptr_in               = ptr_ff + FW'(1);
               if (ptr_ff == flush_len_ff - FW'(1)) begin
                  state_in = (tail_len_ff != 2'd0) ? ST_TAIL : ST_IDLE;
               end else begin
                  state_in = ST_MEM_RD;
               end
            end
         end
         ST_TAIL: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_byte = tail_ff[tail_idx_ff];
               rsp_data_in.last     = (tail_idx_ff == tail_len_ff - 2'd1);
               tail_idx_in          = tail_idx_ff + 2'd1;
               if (tail_idx_ff == tail_len_ff - 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      flush_len_ff <= flush_len_in;
      ptr_ff       <= ptr_in;
      tail_ff      <= tail_in;
      tail_len_ff  <= tail_len_in;
      tail_idx_ff  <= tail_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= name_mem[ptr_ff[AW-1:0]];
   end

   `HESD_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FW'(hesd_pkg::BUFFER_BYTES), "fill count beyond buffer size")
   `HESD_ASSERT_NOW(a_ptr_bound, state_ff == ST_MEM_WR, ptr_ff < flush_len_ff, "flush pointer past flush length")
   `HESD_ASSERT_NOW(a_tail_len, state_ff == ST_TAIL, tail_len_ff != 2'd0, "tail state with no tail bytes")
   `HESD_ASSERT_NEXT(a_empty_end, req_valid && req_ready && req_data.mode && fill_ff == '0, state_ff == ST_IDLE, "empty end of stream left the idle state")

endmodule

FILE: tb/sv/html_entity_stream_decoder_tb.sv
`timescale 1ns / 1ps

module html_entity_stream_decoder_tb;

   localparam bit MODE_DATA = 1'b0;
   localparam bit MODE_END = 1'b1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASE_ITEMS = 25;

   typedef struct {
      bit          mode;
      logic [7:0]  value;
      bit          typed;
      int          count;
      logic [23:0] bytes;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   hesd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   hesd_pkg::rsp_type rsp_data;

   bit          cur_typed = 1'b0;
   int          cur_count = 0;
   logic [23:0] cur_bytes = '0;

   int send_idle = 0;
   int recv_idle = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int items_sent = 0;
   int sequence_count = 0;
   int error_count = 0;
   int unsigned cycle_count = 0;

   logic [7:0]        name_buf [hesd_pkg::BUFFER_BYTES];
   int                fill_count = 0;
   logic [7:0]        step_bytes [$];
   hesd_pkg::rsp_type decoded_q [$];

   string       entity_names [6] = '{"lt", "gt", "amp", "mdash", "minus", "pi"};
   logic [23:0] entity_repl [6] = '{24'h3C0000, 24'h3E0000, 24'h260000,
                                    24'hE28094, 24'hE28892, 24'hCF8000};
   int          entity_repl_len [6] = '{1, 1, 1, 3, 3, 2};

   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{MODE_DATA, 8'h41, 1'b1, 1, 24'h410000},
      '{MODE_DATA, 8'h00, 1'b1, 1, 24'h000000},
      '{MODE_DATA, 8'hFF, 1'b1, 1, 24'hFF0000},
      '{MODE_DATA, hesd_pkg::SEMI_CHAR, 1'b1, 1, 24'h3B0000},
      '{MODE_END, 8'hA5, 1'b1, 0, 24'h000000},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 0, 24'h000000},
      '{MODE_DATA, "l", 1'b1, 0, 24'h000000},
      '{MODE_DATA, "t", 1'b1, 0, 24'h000000},
      '{MODE_DATA, hesd_pkg::SEMI_CHAR, 1'b1, 1, 24'h3C0000},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 0, 24'h000000},
      '{MODE_DATA, "p", 1'b1, 0, 24'h000000},
      '{MODE_DATA, "i", 1'b1, 0, 24'h000000},
      '{MODE_DATA, hesd_pkg::SEMI_CHAR, 1'b1, 2, 24'hCF8000},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 0, 24'h000000},
      '{MODE_DATA, hesd_pkg::SEMI_CHAR, 1'b1, 2, 24'h263B00},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 0, 24'h000000},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 1, 24'h260000},
      '{MODE_DATA, "x", 1'b1, 0, 24'h000000},
      '{MODE_DATA, 8'h20, 1'b0, 0, 24'h000000},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 0, 24'h000000},
      '{MODE_DATA, "q", 1'b1, 0, 24'h000000},
      '{MODE_END, 8'hFF, 1'b1, 2, 24'h267100},
      '{MODE_DATA, hesd_pkg::AMP_CHAR, 1'b1, 0, 24'h000000},
      '{MODE_DATA, "g", 1'b1, 0, 24'h000000},
      '{MODE_DATA, 8'h00, 1'b0, 0, 24'h000000}
   };

   html_entity_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void flush_name();
      for (int i = 0; i < fill_count; i++) begin
         step_bytes.push_back(name_buf[i]);
      end
      fill_count = 0;
   endfunction

   function automatic int entity_index();
      bit hit;
      for (int k = 0; k < 6; k++) begin
         if (fill_count == entity_names[k].len() + 1) begin
            hit = 1'b1;
            for (int i = 0; i < entity_names[k].len(); i++) begin
               if (name_buf[i + 1] != entity_names[k][i]) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               return k;
            end
         end
      end
      return -1;
   endfunction

   function automatic void decode_step(input hesd_pkg::req_type r);
      int idx;
      step_bytes.delete();
      if (r.mode == MODE_END) begin
         flush_name();
      end else if (fill_count != 0) begin
         if (r.in_byte <= hesd_pkg::SPECIAL_MAX) begin
            flush_name();
            step_bytes.push_back(r.in_byte);
         end else if (r.in_byte == hesd_pkg::AMP_CHAR) begin
            flush_name();
            name_buf[0] = hesd_pkg::AMP_CHAR;
            fill_count = 1;
         end else if (r.in_byte == hesd_pkg::SEMI_CHAR) begin
            idx = entity_index();
            if (idx < 0) begin
               flush_name();
               step_bytes.push_back(hesd_pkg::SEMI_CHAR);
            end else begin
               for (int k = 0; k < entity_repl_len[idx]; k++) begin
                  step_bytes.push_back(entity_repl[idx][23 - 8 * k -: 8]);
               end
            end
            fill_count = 0;
         end else if (fill_count >= hesd_pkg::BUFFER_BYTES) begin
            flush_name();
            step_bytes.push_back(r.in_byte);
         end else begin
            name_buf[fill_count] = r.in_byte;
            fill_count++;
         end
      end else if (r.in_byte == hesd_pkg::AMP_CHAR) begin
         name_buf[0] = hesd_pkg::AMP_CHAR;
         fill_count = 1;
      end else begin
         step_bytes.push_back(r.in_byte);
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      hesd_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_step(req_data);
            if (cur_typed) begin
               for (int k = 0; k < cur_count; k++) begin
                  want.out_byte = cur_bytes[23 - 8 * k -: 8];
                  want.last = (k == cur_count - 1);
                  decoded_q.push_back(want);
               end
            end else begin
               for (int k = 0; k < step_bytes.size(); k++) begin
                  want.out_byte = step_bytes[k];
                  want.last = (k == step_bytes.size() - 1);
                  decoded_q.push_back(want);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transfer, actual out_byte %h last %b",
                        $time, rsp_data.out_byte, rsp_data.last);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  error_count++;
                  $display("%0t: out_byte mismatch, expected %h actual %h",
                           $time, want.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.last !== want.last) begin
                  error_count++;
                  $display("%0t: last mismatch, expected %b actual %b",
                           $time, want.last, rsp_data.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_item(input bit mode, input logic [7:0] value, input bit typed,
                            input int count, input logic [23:0] bytes);
      hesd_pkg::req_type r;
      r.mode = mode;
      r.in_byte = value;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      cur_typed <= typed;
      cur_count <= count;
      cur_bytes <= bytes;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_data(input logic [7:0] value);
      send_item(MODE_DATA, value, 1'b0, 0, '0);
   endtask

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(8'h21, 8'hFF));
      end while (b == hesd_pkg::AMP_CHAR || b == hesd_pkg::SEMI_CHAR);
      return b;
   endfunction

   task automatic send_sequence();
      int kind;
      int pick;
      int len;
      int roll;
      if (sequence_count < 6) begin
         kind = sequence_count;
      end else begin
         roll = $urandom_range(99);
         kind = (roll < 30) ? 0 : (roll < 45) ? 1 : (roll < 55) ? 2 :
                (roll < 70) ? 3 : (roll < 90) ? 4 : 5;
      end
      sequence_count++;
      case (kind)
         0: begin
            pick = $urandom_range(5);
            send_data(hesd_pkg::AMP_CHAR);
            for (int i = 0; i < entity_names[pick].len(); i++) begin
               send_data(entity_names[pick][i]);
            end
            send_data(hesd_pkg::SEMI_CHAR);
         end
         1: begin
            len = $urandom_range(1, 5);
            send_data(hesd_pkg::AMP_CHAR);
            for (int i = 0; i < len; i++) begin
               send_data(name_byte());
            end
            send_data(hesd_pkg::SEMI_CHAR);
         end
         2: begin
            len = $urandom_range(13, 17);
            send_data(hesd_pkg::AMP_CHAR);
            for (int i = 0; i < len; i++) begin
               send_data(name_byte());
            end
            pick = $urandom_range(2);
            if (pick == 0) begin
               send_data(hesd_pkg::SEMI_CHAR);
            end else if (pick == 1) begin
               send_data(8'($urandom_range(0, hesd_pkg::SPECIAL_MAX)));
            end else begin
               send_item(MODE_END, 8'($urandom_range(255)), 1'b0, 0, '0);
            end
         end
         3: begin
            len = $urandom_range(0, 4);
            send_data(hesd_pkg::AMP_CHAR);
            for (int i = 0; i < len; i++) begin
               send_data(name_byte());
            end
            pick = $urandom_range(2);
            if (pick == 0) begin
               send_data(8'($urandom_range(0, hesd_pkg::SPECIAL_MAX)));
            end else if (pick == 1) begin
               send_data(hesd_pkg::AMP_CHAR);
            end else begin
               send_item(MODE_END, 8'($urandom_range(255)), 1'b0, 0, '0);
            end
         end
         4: begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               send_data(8'($urandom_range(255)));
            end
         end
         default: begin
            send_item(MODE_END, 8'($urandom_range(255)), 1'b0, 0, '0);
         end
      endcase
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int send_pct [3];
      int recv_pct [3];
      send_pct = '{38, 81, 0};
      recv_pct = '{81, 38, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle = send_pct[0];
      recv_idle = recv_pct[0];
      foreach (directed_table[i]) begin
         send_item(directed_table[i].mode, directed_table[i].value, directed_table[i].typed,
                   directed_table[i].count, directed_table[i].bytes);
      end
      items_sent = 0;
      for (int p = 0; p < 3; p++) begin
         // The sender stops here until every pending transfer has come out.
         wait_for_drain();
         send_idle = send_pct[p];
         recv_idle = recv_pct[p];
         if (p == 2) begin
            hold_request = 1'b1;
         end
         while (items_sent < PHASE_ITEMS * (p + 1)) begin
            send_sequence();
         end
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected transfers never arrived", $time, decoded_q.size());
      end
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
